[rtl/srts_pkg.sv]
// package for sampler region trigger select: field widths, result kinds, setting codes
// no dependencies
`default_nettype none
package srts_pkg;
  localparam int REGIONS_DEF = 16;
  localparam int CHANNELS_DEF = 17;
  localparam int NOTES = 128;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int MAX_RESULTS = 48;
  localparam logic [7:0] UNSET = 8'h80;

  typedef enum logic [2:0] {
    KIND_WRITTEN = 3'd0,
    KIND_SWITCH  = 3'd1,
    KIND_CHOKE   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_START   = 3'd4,
    KIND_NONE    = 3'd5
  } kind_t;

  localparam logic [3:0] SEL_LO_NOTE = 4'd0;
  localparam logic [3:0] SEL_HI_NOTE = 4'd1;
  localparam logic [3:0] SEL_CHOKE = 4'd2;
  localparam logic [3:0] SEL_OFFBY = 4'd3;
  localparam logic [3:0] SEL_SEQ_LEN = 4'd4;
  localparam logic [3:0] SEL_SEQ_POS = 4'd5;
  localparam logic [3:0] SEL_LO_RAND = 4'd6;
  localparam logic [3:0] SEL_HI_RAND = 4'd7;
  localparam logic [3:0] SEL_RAND_ON = 4'd8;
  localparam logic [3:0] SEL_SW_DEF = 4'd9;
  localparam logic [3:0] SEL_SW_LAST = 4'd10;
  localparam logic [3:0] SEL_SW_LO = 4'd11;
  localparam logic [3:0] SEL_SW_HI = 4'd12;
  localparam logic [3:0] SEL_ENABLE = 4'd13;

  // one region's settings as stored
  typedef struct packed {
    logic       enable;
    logic [6:0] lo_note;
    logic [6:0] hi_note;
    logic [7:0] offby;
    logic [7:0] seq_len;
    logic [7:0] seq_pos;
    logic [16:0] lo_rand;
    logic [16:0] hi_rand;
    logic       rand_on;
    logic [7:0] sw_def;
    logic [7:0] sw_last;
    logic [7:0] sw_lo;
    logic [7:0] sw_hi;
  } region_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [3:0] region;
    logic [7:0] group;
    logic [4:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last;
  } result_t;
endpackage
`default_nettype wire

[rtl/srts_modunit.sv]
// shared restoring divider remainder unit: (cnt - 1) mod len, one bit per cycle
// no dependencies
`default_nettype none
module srts_modunit #(
  parameter int CB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [CB-1:0] dividend,
  input  wire logic [7:0]    divisor,
  output logic               done,
  output logic [7:0]         remainder
);
  localparam int SW = $clog2(CB + 1);
  logic [CB-1:0] quo;
  logic [7:0] rem;
  logic [SW-1:0] cnt;
  logic busy;
  logic [8:0] trial;

  // shift in next dividend bit and try subtract
  assign trial = {rem, quo[CB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo <= dividend;
        rem <= '0;
        cnt <= SW'(CB);
      end else if (busy) begin
        quo <= {quo[CB-2:0], 1'b0};
        if (trial >= {1'b0, divisor}) rem <= 8'(trial - {1'b0, divisor});
        else rem <= trial[7:0];
        cnt <= cnt - 1'b1;
        if (cnt == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign remainder = rem;
endmodule
`default_nettype wire

[rtl/sampler_region_trigger_select.sv]
// Sampler region trigger select. A write request is accepted in idle and returns one result.
// A key-switch note-on runs only the switch range scan over all regions. Any other note-on
// runs the scan, advances the round-robin count and then tests each region in turn; a region
// that matches with the sequence test on waits for the remainder of the round-robin count
// minus one by the sequence length, which comes from one shared bit-serial divider. Results
// leave through a one-entry output register behind a one-entry hold register; a result waits
// while m_tready is low. The block takes no new request until the last result of the current
// one is taken.
// The round-robin counts sit in a memory with a registered read and per-note valid bits.
// depends on srts_pkg and srts_modunit
`default_nettype none
module sampler_region_trigger_select
  import srts_pkg::*;
#(
  parameter int REGIONS = REGIONS_DEF,
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // command, region_index, setting_select, setting_value, channel, note, velocity,
  // random_value (from bit 0 up), 61 bits padded to 64
  input  wire logic [63:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_region, group, out_channel, out_note, out_velocity (from bit 0 up), 31 padded to 32
  output logic [31:0]      m_tdata,
  // kind
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);
  localparam int RW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CB = COUNTER_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_COUNT, ST_TEST, ST_DIV, ST_EMIT, ST_OUT, ST_NEXT
  } state_t;

  state_t state;
  region_t regs [REGIONS];
  logic [CB-1:0] rr [NOTES];
  logic [NOTES-1:0] rr_vld;
  logic [7:0] act_sw [CHANNELS];

  // request fields
  logic       in_cmd;
  logic [3:0] in_ri, in_sel;
  logic [16:0] in_val;
  logic [4:0] in_ch;
  logic [6:0] in_note, in_vel;
  logic [15:0] in_rnd;
  assign in_cmd = s_tdata[0];
  assign in_ri = s_tdata[4:1];
  assign in_sel = s_tdata[8:5];
  assign in_val = s_tdata[25:9];
  assign in_ch = s_tdata[30:26];
  assign in_note = s_tdata[37:31];
  assign in_vel = s_tdata[44:38];
  assign in_rnd = s_tdata[60:45];

  // latched note-on
  logic [4:0] ch;
  logic [6:0] note, vel;
  logic [15:0] rnd;
  logic [RW-1:0] idx;
  logic sw_hit;
  logic [CB-1:0] cnt;
  logic [5:0] nres;
  logic [1:0] step;
  logic pend;
  logic [7:0] act;
  logic [7:0] rrem;
  region_t cur;
  result_t res, hold;

  // shared remainder unit
  logic div_start, div_done;
  logic [7:0] div_rem;
  srts_modunit #(.CB(CB)) u_mod (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cnt - 1'b1),
    .divisor(cur.seq_len), .done(div_done), .remainder(div_rem)
  );

  assign cur = regs[idx];
  assign s_tready = (state == ST_IDLE) && !m_tvalid;

  // channel clamp
  logic [4:0] ch_cl;
  assign ch_cl = (in_ch > 5'(CHANNELS - 1)) ? 5'(CHANNELS - 1) : in_ch;

  // setting value saturation
  logic [7:0] v127, v255, vs;
  logic [16:0] vr;
  assign v127 = (in_val > 17'd127) ? 8'd127 : in_val[7:0];
  assign v255 = (in_val > 17'd255) ? 8'd255 : in_val[7:0];
  assign vr = (in_val > 17'd65536) ? 17'd65536 : in_val;
  assign vs = (in_val >= 17'd128) ? UNSET : in_val[7:0];

  // round-robin count memory, read at the latched note during the scan
  logic rr_we;
  logic [CB-1:0] rr_rd, rr_inc, rr_new;
  assign rr_we = (state == ST_COUNT);
  assign rr_inc = (rr_vld[note] ? rr_rd : '0) + 1'b1;
  assign rr_new = (rr_inc == '0) ? CB'(1) : rr_inc;
  always_ff @(posedge clk) begin
    if (rr_we) rr[note] <= rr_new;
    rr_rd <= rr[note];
  end

  // switch range test for current region
  logic [7:0] slo, shi;
  logic range_hit, scan_last;
  always_comb begin
    slo = (cur.sw_lo > cur.sw_hi) ? cur.sw_hi : cur.sw_lo;
    shi = (cur.sw_lo > cur.sw_hi) ? cur.sw_lo : cur.sw_hi;
    range_hit = cur.enable && !cur.sw_lo[7] && !cur.sw_hi[7]
                && {1'b0, note} >= slo && {1'b0, note} <= shi;
  end
  assign scan_last = (32'(idx) == 32'(REGIONS - 1));

  // static match terms for current region (without sequence test)
  logic [16:0] ra, rb;
  logic [7:0] eff_act, pos_cl;
  logic base_ok, seq_on;
  always_comb begin
    ra = (cur.lo_rand > cur.hi_rand) ? cur.hi_rand : cur.lo_rand;
    rb = (cur.lo_rand > cur.hi_rand) ? cur.lo_rand : cur.hi_rand;
    eff_act = act[7] ? cur.sw_def : act;
    pos_cl = (cur.seq_pos > cur.seq_len) ? cur.seq_len : cur.seq_pos;
    seq_on = (cur.seq_len != 8'd0) && (cur.seq_pos != 8'd0);
    base_ok = cur.enable && note >= cur.lo_note && note <= cur.hi_note
              && (cur.sw_last[7] || (!eff_act[7] && eff_act == cur.sw_last))
              && (!cur.rand_on || ({1'b0, rnd} >= ra && {1'b0, rnd} < rb));
  end

  assign div_start = (state == ST_TEST) && base_ok && seq_on;

  // result for the current emit step
  result_t emit_res;
  always_comb begin
    case (step)
      2'd1: emit_res = '{kind: KIND_CHOKE, group: cur.offby, channel: ch, default: '0};
      2'd2: emit_res = '{kind: KIND_RELEASE, channel: ch, note: note, default: '0};
      default: emit_res = '{kind: KIND_START, region: 4'(idx), channel: ch, note: note,
                            velocity: vel, default: '0};
    endcase
  end

  // output register load
  logic out_free, out_load, wr_ok;
  result_t out_data;
  assign out_free = !m_tvalid || m_tready;
  assign wr_ok = ({28'd0, in_ri} < 32'(REGIONS)) && (in_sel <= SEL_ENABLE);
  always_comb begin
    out_load = 1'b0;
    out_data = hold;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready && !in_cmd) begin
          out_load = 1'b1;
          if (wr_ok) out_data = '{kind: KIND_WRITTEN, region: in_ri, last: 1'b1, default: '0};
          else out_data = '{kind: KIND_NONE, last: 1'b1, default: '0};
        end
      end
      ST_SCAN: begin
        if (scan_last && (sw_hit || range_hit)) begin
          out_load = 1'b1;
          out_data = '{kind: KIND_SWITCH, channel: ch, note: note, last: 1'b1, default: '0};
        end
      end
      ST_EMIT: out_load = (step != 2'd0) && pend && out_free;
      ST_OUT: begin
        out_load = out_free;
        if (pend) out_data.last = 1'b1;
        else out_data = '{kind: KIND_NONE, last: 1'b1, default: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_tvalid <= 1'b0;
      pend <= 1'b0;
      nres <= '0;
      rr_vld <= '0;
      for (int i = 0; i < REGIONS; i++) begin
        regs[i] <= '{enable: 1'b0, lo_note: '0, hi_note: '0, offby: '0, seq_len: '0,
                     seq_pos: '0, lo_rand: '0, hi_rand: '0, rand_on: 1'b0,
                     sw_def: UNSET, sw_last: UNSET, sw_lo: UNSET, sw_hi: UNSET};
      end
      for (int i = 0; i < CHANNELS; i++) act_sw[i] <= UNSET;
    end else begin
      m_tvalid <= out_load || !out_free;
      if (out_load) res <= out_data;
      case (state)
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (!in_cmd) begin
              if (wr_ok) begin
                case (in_sel)
                  SEL_LO_NOTE: regs[in_ri[RW-1:0]].lo_note <= v127[6:0];
                  SEL_HI_NOTE: regs[in_ri[RW-1:0]].hi_note <= v127[6:0];
                  SEL_CHOKE: ;
                  SEL_OFFBY: regs[in_ri[RW-1:0]].offby <= v255;
                  SEL_SEQ_LEN: regs[in_ri[RW-1:0]].seq_len <= v255;
                  SEL_SEQ_POS: regs[in_ri[RW-1:0]].seq_pos <= v255;
                  SEL_LO_RAND: regs[in_ri[RW-1:0]].lo_rand <= vr;
                  SEL_HI_RAND: regs[in_ri[RW-1:0]].hi_rand <= vr;
                  SEL_RAND_ON: regs[in_ri[RW-1:0]].rand_on <= in_val[0];
                  SEL_SW_DEF: regs[in_ri[RW-1:0]].sw_def <= vs;
                  SEL_SW_LAST: regs[in_ri[RW-1:0]].sw_last <= vs;
                  SEL_SW_LO: regs[in_ri[RW-1:0]].sw_lo <= vs;
                  SEL_SW_HI: regs[in_ri[RW-1:0]].sw_hi <= vs;
                  SEL_ENABLE: regs[in_ri[RW-1:0]].enable <= in_val[0];
                  default: ;
                endcase
              end
            end else begin
              ch <= ch_cl;
              note <= in_note;
              vel <= in_vel;
              rnd <= in_rnd;
              act <= act_sw[ch_cl[CHW-1:0]];
              idx <= '0;
              sw_hit <= 1'b0;
              nres <= '0;
              pend <= 1'b0;
              state <= ST_SCAN;
            end
          end
        end
        // one region per cycle for the switch range scan
        ST_SCAN: begin
          if (range_hit) sw_hit <= 1'b1;
          if (scan_last) begin
            if (sw_hit || range_hit) begin
              act_sw[ch[CHW-1:0]] <= {1'b0, note};
              state <= ST_IDLE;
            end else begin
              state <= ST_COUNT;
            end
          end else idx <= idx + 1'b1;
        end
        // round-robin advance, count read during the scan
        ST_COUNT: begin
          cnt <= rr_new;
          rr_vld[note] <= 1'b1;
          idx <= '0;
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (!base_ok) state <= ST_NEXT;
          else if (seq_on) state <= ST_DIV;
          else begin
            rrem <= pos_cl - 1'b1;
            state <= ST_EMIT;
            step <= 2'd0;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            rrem <= div_rem;
            state <= ST_EMIT;
            step <= 2'd0;
          end
        end
        // up to three results through the hold register
        ST_EMIT: begin
          if (step == 2'd0) begin
            if ((seq_on && rrem != pos_cl - 1'b1) ||
                (6'(nres) + ((cur.offby != 8'd0) ? 6'd3 : 6'd2) > 6'(MAX_RESULTS)))
              state <= ST_NEXT;
            else step <= (cur.offby != 8'd0) ? 2'd1 : 2'd2;
          end else if (!pend || out_free) begin
            hold <= emit_res;
            pend <= 1'b1;
            nres <= nres + 1'b1;
            if (step == 2'd3) state <= ST_NEXT;
            step <= step + 1'b1;
          end
        end
        ST_NEXT: begin
          if (scan_last) state <= ST_OUT;
          else begin
            idx <= idx + 1'b1;
            state <= ST_TEST;
          end
        end
        // final result: held one marked last, or none
        ST_OUT: begin
          if (out_free) begin
            pend <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tdata = {1'b0, res.velocity, res.note, res.channel, res.group, res.region};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  // result count never exceeds the limit
  assert property (@(posedge clk) disable iff (rst) nres <= 6'(MAX_RESULTS))
    else $error("result count over limit");
  // a held result is never overwritten while waiting
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");
  // no new request while a result is pending
  assert property (@(posedge clk) disable iff (rst) s_tready |-> !m_tvalid && !pend)
    else $error("ready while busy");
endmodule
`default_nettype wire
